[rtl/bbr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bbr_pkg;

    localparam int PIX_W        = 8;
    localparam int SUM_W        = 12;
    localparam int RW           = 13;
    localparam int WREG_W       = 11;
    localparam int HREG_W       = 13;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam int WIDTH_LO     = 3;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_LO    = 3;
    localparam int HEIGHT_HI    = 4096;
    localparam int HEIGHT_RESET = 480;

    // floor(s * 111 / 1000) == (s * RECIP_MUL) >> RECIP_SHIFT for every s below 2296.
    localparam int PROD_W       = 31;
    localparam int RECIP_SHIFT  = 22;
    localparam logic [18:0] RECIP_MUL = 19'd465568;

    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_AW      = 3;
    localparam int FIFO_CW      = 4;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_pix;

    typedef struct packed {
        t_pix top;
        t_pix mid;
    } t_pair;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } t_tag;

    typedef t_pix [2:0][2:0] t_window;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             frame_end;
    } t_result;

endpackage

`default_nettype wire

[rtl/bbr_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bbr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, kind, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

`default_nettype wire

[rtl/bbr_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bbr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;

    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

[rtl/bbr_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module bbr_cfg
    import bbr_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [WREG_W-1:0] o_width,
    output logic      [HREG_W-1:0] o_height,
    output logic                   o_restart
);

    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [WREG_W-1:0] r_width, n_width;
    logic [HREG_W-1:0] r_height, n_height;
    logic [WREG_W-1:0] wr_w;
    logic [HREG_W-1:0] wr_h;
    logic              wr_en;
    t_reg_idx          idx;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_w   = pwdata[WREG_W-1:0];
    assign wr_h   = pwdata[HREG_W-1:0];

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (wr_en) begin
            unique case (idx)
                REG_FRAME_WIDTH: begin
                    if (int'(wr_w) < WIDTH_LO) begin
                        n_width = WREG_W'(WIDTH_LO);
                    end else if (int'(wr_w) > MAX_WIDTH) begin
                        n_width = WREG_W'(MAX_WIDTH);
                    end else begin
                        n_width = wr_w;
                    end
                end
                REG_FRAME_HEIGHT: begin
                    if (int'(wr_h) < HEIGHT_LO) begin
                        n_height = HREG_W'(HEIGHT_LO);
                    end else if (int'(wr_h) > HEIGHT_HI) begin
                        n_height = HREG_W'(HEIGHT_HI);
                    end else begin
                        n_height = wr_h;
                    end
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_height);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WREG_W'(W_RST);
            r_height <= HREG_W'(HEIGHT_RESET);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    assign o_width   = r_width;
    assign o_height  = r_height;
    assign o_restart = wr_en;

endmodule

`default_nettype wire

[rtl/bbr_line_window.sv]
`timescale 1ns / 1ps
`default_nettype none

module bbr_line_window
    import bbr_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_restart,
    input  wire logic [WREG_W-1:0] i_width,
    input  wire logic [HREG_W-1:0] i_height,
    input  wire logic              i_acc,
    input  wire logic              i_kind,
    input  wire t_pix              i_pix,
    output logic                   o_s1_emit,
    output t_tag                   o_tag,
    output t_window                o_window
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = ((AW > WREG_W) ? AW : WREG_W) + 1;

    logic [AW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] w_ext, col_inc;
    logic [AW-1:0] col_eff;
    logic [RW-1:0] h_row;
    logic          in_frame, act;
    t_pix          pix;
    t_tag          tag;

    t_pair         mem [MAX_WIDTH];
    t_pair         r_rd, r_byp_d, rd, wd;
    logic          r_byp_v;

    logic          r_s1_act;
    logic [AW-1:0] r_s1_col;
    t_pix          r_s1_pix;
    t_tag          r_s1_tag;
    logic          r_s2_v;
    t_tag          r_s2_tag;
    t_window       r_win;

    always_comb begin
        w_ext    = CW'(i_width);
        col_eff  = (CW'(r_col) >= w_ext) ? '0 : r_col;
        col_inc  = CW'(col_eff) + CW'(1);
        h_row    = RW'(i_height);
        in_frame = r_row < h_row;
        act      = i_acc && ((i_kind == KIND_PIXEL) || !in_frame);
        pix      = ((i_kind == KIND_PIXEL) && in_frame) ? i_pix : '0;

        tag.emit     = (r_row >= RW'(2)) || ((r_row == RW'(1)) && (col_eff != '0));
        tag.last     = (r_row == h_row + RW'(1)) && (col_eff == '0);
        tag.interior = (col_eff >= AW'(2)) && (r_row >= RW'(2)) && in_frame;

        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (act) begin
            if (tag.last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc >= w_ext) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = col_inc[AW-1:0];
            end
        end
    end

    assign rd     = r_byp_v ? r_byp_d : r_rd;
    assign wd.top = rd.mid;
    assign wd.mid = r_s1_pix;

    // Entry col holds the two previous rows; read here, written back in the next cycle.
    always_ff @(posedge i_clk) begin
        if (r_s1_act) begin
            mem[r_s1_col] <= wd;
        end
        if (act) begin
            r_rd <= mem[col_eff];
        end
    end

    always_ff @(posedge i_clk) begin
        if (act) begin
            r_byp_d  <= wd;
            r_s1_col <= col_eff;
            r_s1_pix <= pix;
            r_s1_tag <= tag;
        end
        r_s2_tag <= r_s1_tag;
        if (r_s1_act) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= rd.top;
            r_win[1][2] <= rd.mid;
            r_win[2][2] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_act <= 1'b0;
            r_s2_v   <= 1'b0;
            r_byp_v  <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_s1_act <= act;
            r_s2_v   <= o_s1_emit;
            if (act) begin
                r_byp_v <= r_s1_act && (r_s1_col == col_eff);
            end
        end
    end

    assign o_s1_emit      = r_s1_act && r_s1_tag.emit;
    assign o_tag.emit     = r_s2_v;
    assign o_tag.interior = r_s2_tag.interior;
    assign o_tag.last     = r_s2_tag.last;
    assign o_window       = r_win;

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_col) < w_ext)
        else $error("column counter reached the row width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h_row + RW'(1))
        else $error("row counter ran past the flush row");

endmodule

`default_nettype wire

[rtl/bbr_kernel.sv]
`timescale 1ns / 1ps
`default_nettype none

module bbr_kernel
    import bbr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_tag    i_tag,
    input  wire t_window i_window,
    output logic         o_busy,
    output logic         o_push,
    output t_result      o_word
);

    logic [SUM_W-1:0] sum_r, sum_g, sum_b;
    logic [SUM_W-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic             r_s3_v, r_s3_int, r_s3_last;
    t_pix             r_s3_ctr;
    logic [PIX_W-1:0] q_r, q_g, q_b;

    function automatic logic [PIX_W-1:0] scale(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(RECIP_MUL);
        return p[RECIP_SHIFT +: PIX_W];
    endfunction

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                sum_r = sum_r + SUM_W'(i_window[r][c].red);
                sum_g = sum_g + SUM_W'(i_window[r][c].green);
                sum_b = sum_b + SUM_W'(i_window[r][c].blue);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_r   <= sum_r;
        r_sum_g   <= sum_g;
        r_sum_b   <= sum_b;
        r_s3_ctr  <= i_window[1][1];
        r_s3_int  <= i_tag.interior;
        r_s3_last <= i_tag.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= i_tag.emit;
        end
    end

    assign q_r = scale(r_sum_r);
    assign q_g = scale(r_sum_g);
    assign q_b = scale(r_sum_b);

    assign o_busy           = r_s3_v;
    assign o_push           = r_s3_v;
    assign o_word.red_out   = r_s3_int ? q_r : r_s3_ctr.red;
    assign o_word.green_out = r_s3_int ? q_g : r_s3_ctr.green;
    assign o_word.blue_out  = r_s3_int ? q_b : r_s3_ctr.blue;
    assign o_word.frame_end = r_s3_last;

    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_v && r_s3_int) |-> (q_r != 8'hFF) && (q_g != 8'hFF) && (q_b != 8'hFF))
        else $error("scaled sum exceeded the largest blur value");

endmodule

`default_nettype wire

[rtl/bbr_out_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module bbr_out_fifo
    import bbr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire t_result            i_word,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_result                 o_word,
    output logic      [FIFO_CW-1:0] o_count
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_CW-1:0] r_cnt, n_cnt;
    logic               pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_word  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + FIFO_CW'(1);
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - FIFO_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |-> (r_cnt < FIFO_CW'(FIFO_DEPTH)))
        else $error("result queue written while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue count out of range");

endmodule

`default_nettype wire

[rtl/box_blur_3x3_rgb_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                   Word
// in_ch     in   valid/ready                 kind, red_in, green_in, blue_in
// out_ch    out  valid/ready                 red_out, green_out, blue_out, frame_end
// APB       in   psel/penable/pwrite, pready frame_width at 0x0, frame_height at 0x4
//
// One word is accepted per cycle while in_ch is ready; the line buffer is read in the
// accept cycle and written back in the next cycle through its single write port.
// A result is registered in the line window, then in the kernel, then queued before out_ch.
// in_ch stalls only when the eight-word result queue plus the words in flight is full.
// Reset is synchronous and clears counters and valid flags; the line buffer is not cleared.

module box_blur_3x3_rgb_unit
    import bbr_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    bbr_in_if.sink                 in_ch,
    bbr_out_if.source              out_ch,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    logic [WREG_W-1:0]  width;
    logic [HREG_W-1:0]  height;
    logic               restart;
    logic               in_acc;
    logic               s1_emit;
    t_tag               s2_tag;
    t_window            window;
    logic               s3_busy;
    logic               push;
    t_result            push_word, out_word;
    logic [FIFO_CW-1:0] fifo_cnt;
    logic [FIFO_CW:0]   pending;
    t_pix               in_pix;

    assign pending = (FIFO_CW + 1)'(fifo_cnt) + (FIFO_CW + 1)'(s1_emit)
                   + (FIFO_CW + 1)'(s2_tag.emit) + (FIFO_CW + 1)'(s3_busy);

    assign in_ch.ready  = pending < (FIFO_CW + 1)'(FIFO_DEPTH);
    assign in_acc       = in_ch.valid && in_ch.ready;
    assign in_pix.red   = in_ch.red_in;
    assign in_pix.green = in_ch.green_in;
    assign in_pix.blue  = in_ch.blue_in;

    bbr_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_width   (width),
        .o_height  (height),
        .o_restart (restart)
    );

    bbr_line_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_width   (width),
        .i_height  (height),
        .i_acc     (in_acc),
        .i_kind    (in_ch.kind),
        .i_pix     (in_pix),
        .o_s1_emit (s1_emit),
        .o_tag     (s2_tag),
        .o_window  (window)
    );

    bbr_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (s2_tag),
        .i_window (window),
        .o_busy   (s3_busy),
        .o_push   (push),
        .o_word   (push_word)
    );

    bbr_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_valid (out_ch.valid),
        .i_ready (out_ch.ready),
        .o_word  (out_word),
        .o_count (fifo_cnt)
    );

    assign out_ch.red_out   = out_word.red_out;
    assign out_ch.green_out = out_word.green_out;
    assign out_ch.blue_out  = out_word.blue_out;
    assign out_ch.frame_end = out_word.frame_end;

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pending <= (FIFO_CW + 1)'(FIFO_DEPTH))
        else $error("results in flight exceed the result queue depth");

endmodule

`default_nettype wire
